/* rtl/rlcs_pkg.sv */
// Shared types, constants and log2 helpers for the RGB contrast stretch.
`default_nettype none

package rlcs_pkg;

  localparam int MANT_W     = 32;
  localparam int EXP_W      = 5;
  localparam int THR_W      = 15;
  localparam int LEVEL_W    = 8;
  localparam int NBAND      = 3;
  localparam int NUM_THR    = 2 * NBAND;
  localparam int CFG_IDX_W  = 3;
  localparam int THR_IDX_W  = 3;
  localparam int DIV_STEPS  = LEVEL_W;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 8'd255;
  localparam logic [THR_W-1:0]   THR_LOW_RST  = 15'd245;
  localparam logic [THR_W-1:0]   THR_HIGH_RST = 15'd8103;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE,
    CFG_BLUE_LOW,
    CFG_BLUE_HIGH,
    CFG_GREEN_LOW,
    CFG_GREEN_HIGH,
    CFG_RED_LOW,
    CFG_RED_HIGH
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_LOAD,
    SEQ_SQUARE
  } seq_state_e;

  typedef struct packed {
    logic              frac_bit;
    logic [MANT_W-1:0] mant;
  } sq_t;

  // Index of the highest set bit; zero gives zero.
  function automatic logic [EXP_W-1:0] msb_index(input logic [MANT_W-1:0] x);
    logic [EXP_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < MANT_W; i++) begin
      if (x[i]) idx = EXP_W'(i);
    end
    return idx;
  endfunction

  // Shift the leading one up to bit 31, giving a Q1.31 mantissa.
  function automatic logic [MANT_W-1:0] normalize(input logic [MANT_W-1:0] x,
                                                  input logic [EXP_W-1:0]  e);
    logic [MANT_W-1:0] r;
    r = x << (5'd31 - e);
    return r;
  endfunction

  // Square the mantissa; an overflow past 2.0 yields a one bit and a halving.
  function automatic sq_t square_step(input logic [MANT_W-1:0] m);
    logic [2*MANT_W-1:0] p;
    sq_t                 s;
    p = {{MANT_W{1'b0}}, m} * {{MANT_W{1'b0}}, m};
    if (p[2*MANT_W-1]) begin
      s.frac_bit = 1'b1;
      s.mant     = p[2*MANT_W-1:MANT_W];
    end else begin
      s.frac_bit = 1'b0;
      s.mant     = p[2*MANT_W-2:MANT_W-1];
    end
    return s;
  endfunction

endpackage

`default_nettype wire

/* rtl/rgb_log_linear_contrast_stretch.sv */
// Top level: pipelined linear or log2 contrast stretch of a BGR pixel to 8-bit RGB.
//
// Input stream s_axis: one pixel word per beat, blue, green and red samples packed
// from the low bits up. Output stream m_axis: red, green, blue levels from bit 0 up.
// Config channel cfg_*: cfg_index_i picks the register (0 mode, 1..6 band low/high
// thresholds in blue, green, red order), cfg_data_i carries the value.
// Throughput is one pixel per clock while no log pass runs and the output does not
// stall. The input register loads at the accept edge, then come one stage for
// normalizing, one per log fraction bit (a 32x32 squaring each), a compare stage, a
// numerator stage, eight restoring division stages and the output register.
// Threshold logs come from a shared squaring sequencer that makes one pass over all
// six thresholds after reset and after every config write; during that pass
// s_axis_tready and cfg_ready_o are low.
// Reset clears all valid bits and loads the default thresholds and linear mode.
// When the receiver stalls, the next result to arrive parks in a skid register and
// input is still taken until then; once the skid is full the whole pipeline holds.
`default_nettype none

module rgb_log_linear_contrast_stretch #(
  parameter int SAMPLE_BITS       = 16,
  parameter int LOG_FRACTION_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  // tdata: blue_sample, green_sample, red_sample (lowest bit up), zero padded
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  input  wire logic [((3*SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
  // tdata: red_level, green_level, blue_level (lowest bit up)
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  output logic [3*rlcs_pkg::LEVEL_W-1:0]             m_axis_tdata,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [rlcs_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [rlcs_pkg::THR_W-1:0]            cfg_data_i
);

  localparam int LFB    = LOG_FRACTION_BITS;
  localparam int SB     = SAMPLE_BITS;
  localparam int LOG_W  = LFB + rlcs_pkg::EXP_W;
  localparam int VW0    = (SB > LOG_W) ? SB : LOG_W;
  localparam int VW     = (VW0 > rlcs_pkg::THR_W) ? VW0 : rlcs_pkg::THR_W;
  localparam int NW     = VW + rlcs_pkg::LEVEL_W + 1;
  localparam int STEP_W = $clog2(LFB);
  localparam int NB     = rlcs_pkg::NBAND;
  localparam int MW     = rlcs_pkg::MANT_W;
  localparam int LW     = rlcs_pkg::LEVEL_W;
  localparam int DS     = rlcs_pkg::DIV_STEPS;
  localparam int TIW    = rlcs_pkg::THR_IDX_W;

  // ---------------------------------------------------------------- config
  logic                        mode_q;
  logic [rlcs_pkg::THR_W-1:0]  thr_q [0:rlcs_pkg::NUM_THR-1];
  logic [LOG_W-1:0]            log_q [0:rlcs_pkg::NUM_THR-1];
  logic                        cfg_acc;
  logic                        seq_busy;

  assign cfg_ready_o = !seq_busy;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      for (int i = 0; i < rlcs_pkg::NUM_THR; i++) begin
        thr_q[i] <= i[0] ? rlcs_pkg::THR_HIGH_RST : rlcs_pkg::THR_LOW_RST;
      end
    end else if (cfg_acc) begin
      unique case (rlcs_pkg::cfg_idx_e'(cfg_index_i))
        rlcs_pkg::CFG_MODE: mode_q <= cfg_data_i[0];
        rlcs_pkg::CFG_BLUE_LOW, rlcs_pkg::CFG_BLUE_HIGH,
        rlcs_pkg::CFG_GREEN_LOW, rlcs_pkg::CFG_GREEN_HIGH,
        rlcs_pkg::CFG_RED_LOW, rlcs_pkg::CFG_RED_HIGH:
          thr_q[TIW'(cfg_index_i) - TIW'(1)] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------- threshold log sequencer
  rlcs_pkg::seq_state_e seq_state_q, seq_state_d;
  logic [TIW-1:0]       seq_sel_q;
  logic [STEP_W-1:0]    seq_step_q;
  logic [MW-1:0]        seq_m_q;
  logic [LOG_W-1:0]     seq_acc_q;
  logic                 seq_last;
  logic                 seq_last_thr;
  logic                 log_we;
  logic [MW-1:0]        seq_x;
  logic [rlcs_pkg::EXP_W-1:0] seq_e;
  rlcs_pkg::sq_t        seq_sq;
  logic [LOG_W-1:0]     seq_acc_next;

  assign seq_last     = seq_step_q == STEP_W'(LFB - 1);
  assign seq_last_thr = seq_sel_q == TIW'(rlcs_pkg::NUM_THR - 1);
  // A zero threshold takes the log of one.
  assign seq_x        = (thr_q[seq_sel_q] == '0) ? MW'(1) : MW'(thr_q[seq_sel_q]);
  assign seq_e        = rlcs_pkg::msb_index(seq_x);
  assign seq_sq       = rlcs_pkg::square_step(seq_m_q);
  assign seq_acc_next = {seq_acc_q[LOG_W-2:0], seq_sq.frac_bit};

  always_comb begin
    seq_state_d = seq_state_q;
    unique case (seq_state_q)
      rlcs_pkg::SEQ_IDLE:   if (cfg_acc) seq_state_d = rlcs_pkg::SEQ_LOAD;
      rlcs_pkg::SEQ_LOAD:   seq_state_d = rlcs_pkg::SEQ_SQUARE;
      rlcs_pkg::SEQ_SQUARE: begin
        if (seq_last) seq_state_d = seq_last_thr ? rlcs_pkg::SEQ_IDLE : rlcs_pkg::SEQ_LOAD;
      end
      default: seq_state_d = rlcs_pkg::SEQ_IDLE;
    endcase
  end

  always_comb begin
    seq_busy = seq_state_q != rlcs_pkg::SEQ_IDLE;
    log_we   = (seq_state_q == rlcs_pkg::SEQ_SQUARE) && seq_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_state_q <= rlcs_pkg::SEQ_LOAD;
      seq_sel_q   <= '0;
      seq_step_q  <= '0;
    end else begin
      seq_state_q <= seq_state_d;
      unique case (seq_state_q)
        rlcs_pkg::SEQ_IDLE:   seq_sel_q <= '0;
        rlcs_pkg::SEQ_LOAD:   seq_step_q <= '0;
        rlcs_pkg::SEQ_SQUARE: begin
          seq_step_q <= seq_step_q + STEP_W'(1);
          if (seq_last) seq_sel_q <= seq_sel_q + TIW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_state_q == rlcs_pkg::SEQ_LOAD) begin
      seq_m_q   <= rlcs_pkg::normalize(seq_x, seq_e);
      seq_acc_q <= LOG_W'(seq_e);
    end else begin
      seq_m_q   <= seq_sq.mant;
      seq_acc_q <= seq_acc_next;
    end
    if (log_we) log_q[seq_sel_q] <= seq_acc_next;
  end

  // ---------------------------------------------------------------- pipeline
  logic adv;
  logic skid_vld_q;
  logic out_vld_q;

  assign adv           = !skid_vld_q;
  assign s_axis_tready = adv && !seq_busy;

  logic                        in_vld_q;
  logic [SB-1:0]               in_raw_q  [0:NB-1];
  logic [LFB:0]                sq_vld_q;
  logic [VW-1:0]               sq_val_q  [0:LFB][0:NB-1];
  logic [MW-1:0]               sq_m_q    [0:LFB][0:NB-1];
  logic                        sq_pos_q  [0:LFB][0:NB-1];
  rlcs_pkg::sq_t               sq_res    [1:LFB][0:NB-1];
  logic                        cmp_vld_q;
  logic                        cmp_low_q [0:NB-1];
  logic                        cmp_high_q[0:NB-1];
  logic [VW-1:0]               cmp_diff_q[0:NB-1];
  logic [VW-1:0]               cmp_den_q [0:NB-1];
  logic [DS:0]                 div_vld_q;
  logic [NW-1:0]               div_rem_q [0:DS][0:NB-1];
  logic [VW-1:0]               div_den_q [0:DS][0:NB-1];
  logic [LW-1:0]               div_quo_q [0:DS][0:NB-1];
  logic                        div_low_q [0:DS][0:NB-1];
  logic                        div_high_q[0:DS][0:NB-1];
  logic [MW-1:0]               nrm_x     [0:NB-1];
  logic [rlcs_pkg::EXP_W-1:0]  nrm_e     [0:NB-1];
  logic [VW-1:0]               cmp_lo    [0:NB-1];
  logic [VW-1:0]               cmp_hi    [0:NB-1];
  logic [LW-1:0]               res_level [0:NB-1];
  logic [3*LW-1:0]             res_word;
  logic                        pv;

  always_comb begin
    for (int b = 0; b < NB; b++) begin
      nrm_x[b] = MW'(in_raw_q[b]);
      nrm_e[b] = rlcs_pkg::msb_index(nrm_x[b]);
      cmp_lo[b] = mode_q ? VW'(log_q[2*b])   : VW'(thr_q[2*b]);
      cmp_hi[b] = mode_q ? VW'(log_q[2*b+1]) : VW'(thr_q[2*b+1]);
      for (int j = 1; j <= LFB; j++) begin
        sq_res[j][b] = rlcs_pkg::square_step(sq_m_q[j-1][b]);
      end
      // Low test wins over high test.
      if (div_low_q[DS][b])       res_level[b] = '0;
      else if (div_high_q[DS][b]) res_level[b] = rlcs_pkg::LEVEL_MAX;
      else                        res_level[b] = div_quo_q[DS][b];
    end
  end

  // Bands run blue, green, red; the word carries red in the low byte.
  assign res_word = {res_level[0], res_level[1], res_level[2]};
  assign pv       = div_vld_q[DS] && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      sq_vld_q  <= '0;
      cmp_vld_q <= 1'b0;
      div_vld_q <= '0;
    end else if (adv) begin
      in_vld_q  <= s_axis_tvalid && s_axis_tready;
      sq_vld_q  <= {sq_vld_q[LFB-1:0], in_vld_q};
      cmp_vld_q <= sq_vld_q[LFB];
      div_vld_q <= {div_vld_q[DS-1:0], cmp_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int b = 0; b < NB; b++) begin
        in_raw_q[b] <= s_axis_tdata[b*SB +: SB];

        // normalize
        sq_pos_q[0][b] <= (in_raw_q[b] != '0) && !in_raw_q[b][SB-1];
        sq_m_q[0][b]   <= rlcs_pkg::normalize(nrm_x[b], nrm_e[b]);
        sq_val_q[0][b] <= mode_q ? VW'(nrm_e[b]) : VW'(in_raw_q[b]);

        // one fraction bit per stage
        for (int j = 1; j <= LFB; j++) begin
          sq_pos_q[j][b] <= sq_pos_q[j-1][b];
          sq_m_q[j][b]   <= sq_res[j][b].mant;
          sq_val_q[j][b] <= mode_q ? {sq_val_q[j-1][b][VW-2:0], sq_res[j][b].frac_bit}
                                   : sq_val_q[j-1][b];
        end

        // compare against thresholds
        cmp_low_q[b]  <= !sq_pos_q[LFB][b] || (sq_val_q[LFB][b] <= cmp_lo[b]);
        cmp_high_q[b] <= sq_val_q[LFB][b] >= cmp_hi[b];
        cmp_diff_q[b] <= sq_val_q[LFB][b] - cmp_lo[b];
        cmp_den_q[b]  <= cmp_hi[b] - cmp_lo[b];

        // numerator 255*diff + den - 1 for a ceiling quotient
        div_rem_q[0][b]  <= (NW'(cmp_diff_q[b]) << LW) - NW'(cmp_diff_q[b])
                            + NW'(cmp_den_q[b]) - NW'(1);
        div_den_q[0][b]  <= cmp_den_q[b];
        div_quo_q[0][b]  <= '0;
        div_low_q[0][b]  <= cmp_low_q[b];
        div_high_q[0][b] <= cmp_high_q[b];

        // restoring division, quotient bit msb first
        for (int k = 1; k <= DS; k++) begin
          if (div_rem_q[k-1][b] >= (NW'(div_den_q[k-1][b]) << (DS - k))) begin
            div_rem_q[k][b] <= div_rem_q[k-1][b] - (NW'(div_den_q[k-1][b]) << (DS - k));
            div_quo_q[k][b] <= {div_quo_q[k-1][b][LW-2:0], 1'b1};
          end else begin
            div_rem_q[k][b] <= div_rem_q[k-1][b];
            div_quo_q[k][b] <= {div_quo_q[k-1][b][LW-2:0], 1'b0};
          end
          div_den_q[k][b]  <= div_den_q[k-1][b];
          div_low_q[k][b]  <= div_low_q[k-1][b];
          div_high_q[k][b] <= div_high_q[k-1][b];
        end
      end
    end
  end

  // ------------------------------------------------------- output and skid
  logic [3*LW-1:0] out_word_q;
  logic [3*LW-1:0] skid_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_vld_q && !m_axis_tready) begin
      if (pv) skid_vld_q <= 1'b1;
    end else if (skid_vld_q) begin
      out_vld_q  <= 1'b1;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q <= pv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_vld_q && !m_axis_tready) begin
      if (pv) skid_word_q <= res_word;
    end else if (skid_vld_q) begin
      out_word_q <= skid_word_q;
    end else if (pv) begin
      out_word_q <= res_word;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_word_q;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q) else $error("skid holds a word with output empty");

  a_skid_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> !pv) else $error("pipeline advanced into a full skid");

  a_no_input_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_busy |-> !s_axis_tready) else $error("input taken during log pass");

  a_cfg_starts_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_acc |=> seq_busy) else $error("config write did not start log pass");

  a_load_then_square: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_state_q == rlcs_pkg::SEQ_LOAD) |=> (seq_state_q == rlcs_pkg::SEQ_SQUARE))
    else $error("sequencer skipped squaring");
`endif

endmodule

`default_nettype wire

/* bench/rgb_log_linear_contrast_stretch_checker.sv */
// Checker: watches the pixel, level and config channels, predicts levels and compares.
`timescale 1ns / 1ps

module rgb_log_linear_contrast_stretch_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        pix_valid_i,
  input  wire logic        pix_ready_i,
  input  wire logic [47:0] pix_data_i,
  input  wire logic        lvl_valid_i,
  input  wire logic        lvl_ready_i,
  input  wire logic [23:0] lvl_data_i,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_i,
  input  wire logic [rlcs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [rlcs_pkg::THR_W-1:0]     cfg_data_i,
  output int               errors_o,
  output int               pending_o
);

  logic                       log_mode;
  logic [rlcs_pkg::THR_W-1:0] thr_low [rlcs_pkg::NBAND];   // blue, green, red
  logic [rlcs_pkg::THR_W-1:0] thr_high[rlcs_pkg::NBAND];
  logic [23:0]                level_q[$];        // expected {blue, green, red} levels

  // Fixed-point log2 with 16 fraction bits; zero counts as one.
  function automatic logic [31:0] fixed_log2(input logic [31:0] x);
    logic [63:0] m;
    logic [15:0] frac;
    int          e;
    if (x == 0) x = 1;
    e = 0;
    for (int i = 0; i < 32; i++) if (x[i]) e = i;
    m = {32'd0, x} << (31 - e);
    frac = '0;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    return {11'd0, e[4:0], frac};
  endfunction

  function automatic logic [7:0] stretch_level(input logic [15:0] s,
                                               input logic [rlcs_pkg::THR_W-1:0] lo_r,
                                               input logic [rlcs_pkg::THR_W-1:0] hi_r);
    logic [63:0] v, lo, hi, num, den;
    if (s == 0 || s[15]) return 8'd0;
    v = s; lo = lo_r; hi = hi_r;
    if (log_mode) begin
      v = fixed_log2(v[31:0]);
      lo = fixed_log2(lo[31:0]);
      hi = fixed_log2(hi[31:0]);
    end
    if (v <= lo) return 8'd0;
    if (v >= hi) return rlcs_pkg::LEVEL_MAX;
    num = 255 * (v - lo);
    den = hi - lo;
    return 8'((num + den - 1) / den);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [23:0] want;
    logic [23:0] pred;
    if (!rst_ni) begin
      log_mode = 1'b0;
      for (int b = 0; b < rlcs_pkg::NBAND; b++) begin
        thr_low[b]  = rlcs_pkg::THR_LOW_RST;
        thr_high[b] = rlcs_pkg::THR_HIGH_RST;
      end
      level_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (lvl_valid_i && lvl_ready_i) begin
        if (level_q.size() == 0) begin
          $display("%0t: unexpected level word %h", $time, lvl_data_i);
          errors_o++;
        end else begin
          want = level_q.pop_front();
          for (int f = 0; f < 3; f++)
            if (lvl_data_i[f*8 +: 8] !== want[f*8 +: 8]) begin
              $display("%0t: level field %0d expected %0d actual %0d",
                       $time, f, want[f*8 +: 8], lvl_data_i[f*8 +: 8]);
              errors_o++;
            end
        end
      end
      if (pix_valid_i && pix_ready_i) begin
        // Output order is red, green, blue from bit 0; input is blue, green, red.
        for (int b = 0; b < rlcs_pkg::NBAND; b++)
          pred[(2-b)*8 +: 8] = stretch_level(pix_data_i[b*16 +: 16], thr_low[b], thr_high[b]);
        level_q.push_back(pred);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        unique case (rlcs_pkg::cfg_idx_e'(cfg_index_i))
          rlcs_pkg::CFG_MODE:       log_mode    = cfg_data_i[0];
          rlcs_pkg::CFG_BLUE_LOW:   thr_low[0]  = cfg_data_i;
          rlcs_pkg::CFG_BLUE_HIGH:  thr_high[0] = cfg_data_i;
          rlcs_pkg::CFG_GREEN_LOW:  thr_low[1]  = cfg_data_i;
          rlcs_pkg::CFG_GREEN_HIGH: thr_high[1] = cfg_data_i;
          rlcs_pkg::CFG_RED_LOW:    thr_low[2]  = cfg_data_i;
          rlcs_pkg::CFG_RED_HIGH:   thr_high[2] = cfg_data_i;
          default: ;
        endcase
      end
      pending_o = level_q.size();
    end
  end
endmodule

/* bench/rgb_log_linear_contrast_stretch_tb.sv */
// Testbench top: drives pixels and config writes, gives the verdict.
`timescale 1ns / 1ps

module rgb_log_linear_contrast_stretch_tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [rlcs_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [rlcs_pkg::THR_W-1:0]     cfg_data_i = '0;
  int          errors, pending;
  int          send_idle_pct = 14;
  int          recv_idle_pct = 73;

  localparam int SETTLE = 40;
  // Index past the last register; writes to it are dropped.
  localparam logic [rlcs_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  rgb_log_linear_contrast_stretch u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  rgb_log_linear_contrast_stretch_checker u_chk (
    .clk_i, .rst_ni,
    .pix_valid_i(s_axis_tvalid), .pix_ready_i(s_axis_tready), .pix_data_i(s_axis_tdata),
    .lvl_valid_i(m_axis_tvalid), .lvl_ready_i(m_axis_tready), .lvl_data_i(m_axis_tdata),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  always @(negedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

  initial begin
    #4_000_000;
    $display("rgb_log_linear_contrast_stretch test failed");
    $finish;
  end

  // Returns at the accepting rising edge; the caller's next step starts at the falling one.
  task automatic send_pixel(input logic [15:0] blue, input logic [15:0] green,
                            input logic [15:0] red);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {red, green, blue};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_levels;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [rlcs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rlcs_pkg::THR_W-1:0] val);
    drain_levels();
    repeat (SETTLE) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic write_thresholds(input logic [rlcs_pkg::THR_W-1:0] lo,
                                  input logic [rlcs_pkg::THR_W-1:0] hi);
    write_reg(rlcs_pkg::CFG_BLUE_LOW, lo);
    write_reg(rlcs_pkg::CFG_BLUE_HIGH, hi);
    write_reg(rlcs_pkg::CFG_GREEN_LOW, lo);
    write_reg(rlcs_pkg::CFG_GREEN_HIGH, hi);
    write_reg(rlcs_pkg::CFG_RED_LOW, lo);
    write_reg(rlcs_pkg::CFG_RED_HIGH, hi);
  endtask

  function automatic logic [15:0] rand_sample(input logic [rlcs_pkg::THR_W-1:0] lo,
                                              input logic [rlcs_pkg::THR_W-1:0] hi);
    int k;
    k = $urandom_range(9);
    if (k < 2) return 16'($urandom());
    if (k < 4) return 16'($urandom_range(32767));
    if (k == 4) return 16'($urandom_range(3));
    return 16'($urandom_range((lo < hi) ? hi + 20 : lo + 20, (lo > 20) ? lo - 20 : 0));
  endfunction

  logic [15:0] edges[12] = '{16'd0, 16'hFFFF, 16'h8000, 16'h7FFF, 16'd1, 16'd245,
                             16'd246, 16'd8102, 16'd8103, 16'd8104, 16'd1000, 16'd2};
  logic [rlcs_pkg::THR_W-1:0] lo_s, hi_s;

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: linear at reset thresholds, then log, then threshold extremes.
    for (int i = 0; i < 12; i++) send_pixel(edges[i], edges[(i+3)%12], edges[(i+7)%12]);
    write_reg(rlcs_pkg::CFG_MODE, 15'h7FFF);
    for (int i = 0; i < 6; i++) send_pixel(edges[i+6], edges[i], edges[11-i]);
    write_reg(CFG_UNUSED, 15'd1);
    write_thresholds(15'd32767, 15'd1);
    send_pixel(16'd1, 16'd32767, 16'd500);
    write_thresholds(15'd0, 15'd32767);
    send_pixel(16'd1, 16'd32767, 16'd500);
    write_reg(rlcs_pkg::CFG_MODE, 15'h7FFE);   // upper bits ignored: linear
    send_pixel(16'd1, 16'd32767, 16'd16000);

    for (int seg = 0; seg < 10; seg++) begin
      if (seg < 3) begin
        send_idle_pct = 14; recv_idle_pct = 73;
      end else if (seg < 6) begin
        send_idle_pct = 73; recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      lo_s = rlcs_pkg::THR_W'($urandom_range(32767, 1));
      hi_s = rlcs_pkg::THR_W'($urandom_range(32767, 1));
      if (seg == 9) begin
        lo_s = 15'd1; hi_s = 15'd32767;
      end else if (seg % 4 != 3 && lo_s > hi_s) begin
        {lo_s, hi_s} = {hi_s, lo_s};
      end
      write_reg(rlcs_pkg::CFG_MODE, rlcs_pkg::THR_W'(seg % 2));
      write_thresholds(lo_s, hi_s);
      for (int i = 0; i < 75; i++) begin
        send_pixel(rand_sample(lo_s, hi_s), rand_sample(lo_s, hi_s), rand_sample(lo_s, hi_s));
        if (seg == 4 && i == 30) drain_levels();
      end
    end

    drain_levels();
    repeat (SETTLE) @(negedge clk_i);
    if (errors == 0) $display("rgb_log_linear_contrast_stretch test passed");
    else $display("rgb_log_linear_contrast_stretch test failed");
    $finish;
  end
endmodule
